// File: design/lktm_pkg.sv
// ----------------------------------------------------------------------------
// lktm_pkg: shared types and constants of the keyed Lamport table merge
// Holds the table geometry, the message kinds, the item, entry and result
// records, and the state encoding of the back-end sequencer.
// ----------------------------------------------------------------------------
package lktm_pkg;

  // Table geometry.
  localparam int unsigned TableDepth = 16;
  localparam int unsigned TableAw    = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  // Depth of the queue between the front and the back end.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Field widths.
  localparam int unsigned KeyW   = 16;
  localparam int unsigned StampW = 8;
  localparam int unsigned RobotW = 16;
  localparam int unsigned ValueW = 24;
  localparam int unsigned EntryW = KeyW + RobotW + ValueW + StampW;

  // Reset values of the configuration registers.
  localparam logic [StampW-1:0] WindowReset = 8'd50;
  localparam logic [RobotW-1:0] OwnIdReset  = 16'd0;

  // Configuration register indexes.
  localparam logic CfgNewerWindow = 1'b0;
  localparam logic CfgOwnRobotId  = 1'b1;

  typedef enum logic {
    FuncPut   = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [KeyW-1:0]    entry_key;
    logic [StampW-1:0]  stamp;
    logic [RobotW-1:0]  sender_id;
    logic [ValueW-1:0]  value_word;
  } item_t;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [RobotW-1:0]  robot;
    logic [ValueW-1:0]  value;
    logic [StampW-1:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic               table_full;
    logic               put_valid;
    logic [StampW-1:0]  out_stamp;
    logic [ValueW-1:0]  out_value;
    logic [KeyW-1:0]    out_key;
    logic [RobotW-1:0]  out_robot;
  } result_t;

  typedef struct packed {
    logic [StampW-1:0]  newer_window;
    logic [RobotW-1:0]  own_robot_id;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0]    used_slots;
  } status_t;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StResolve
  } bk_state_e;

endpackage

// File: design/lktm_ram.sv
// ----------------------------------------------------------------------------
// lktm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lktm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lktm_front.sv
// ----------------------------------------------------------------------------
// lktm_front: message intake and queue
// Accepts stream transactions, unpacks and classifies each message, and
// holds it in a short queue until the back end takes it.
// ----------------------------------------------------------------------------
module lktm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [63:0]         s_axis_tdata_i,
  input  logic                s_axis_tuser_i,
  output logic                item_valid_o,
  output lktm_pkg::item_t     item_o,
  input  logic                item_pop_i
);

  lktm_pkg::item_t                   fifo_q [lktm_pkg::QueueDepth];
  logic [lktm_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [lktm_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [lktm_pkg::QCntW-1:0]        cnt_q, cnt_d;
  lktm_pkg::item_t                   in_item;
  logic                              push, pop;

  // Unpack and classify the incoming message.
  always_comb begin
    in_item.func       = lktm_pkg::func_e'(s_axis_tuser_i);
    in_item.entry_key  = s_axis_tdata_i[15:0];
    in_item.stamp      = s_axis_tdata_i[23:16];
    in_item.sender_id  = s_axis_tdata_i[39:24];
    in_item.value_word = s_axis_tdata_i[63:40];
  end

  assign s_axis_tready_o = (cnt_q != lktm_pkg::QCntW'(lktm_pkg::QueueDepth));
  assign item_valid_o    = (cnt_q != '0);
  assign item_o          = fifo_q[rd_ptr_q];
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = item_valid_o && item_pop_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == lktm_pkg::QPtrW'(lktm_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + lktm_pkg::QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == lktm_pkg::QPtrW'(lktm_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + lktm_pkg::QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + lktm_pkg::QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - lktm_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

// File: design/lktm_back.sv
// ----------------------------------------------------------------------------
// lktm_back: table search, merge and result register
// Walks the filled slots for the key, applies the last-writer-wins rule,
// writes the table back and presents one result per message.
// ----------------------------------------------------------------------------
module lktm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lktm_pkg::cfg_t      cfg_i,
  input  logic                item_valid_i,
  input  lktm_pkg::item_t     item_i,
  output logic                item_pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [63:0]         m_axis_tdata_o,
  output logic [1:0]          m_axis_tuser_o,
  output lktm_pkg::status_t   status_o
);

  lktm_pkg::bk_state_e               state_q, state_d;
  lktm_pkg::item_t                   cur_q, cur_d;
  lktm_pkg::entry_t                  hit_entry_q, hit_entry_d;
  logic [lktm_pkg::TableAw-1:0]      hit_addr_q, hit_addr_d;
  logic                              hit_q, hit_d;
  logic [lktm_pkg::CntW-1:0]         idx_q, idx_d, idx_m1;
  logic                              pend_q, pend_d;
  logic [lktm_pkg::CntW-1:0]         used_q, used_d;
  logic                              out_valid_q, out_valid_d;
  lktm_pkg::result_t                 out_q, out_d;

  logic                              rd_en, wr_en;
  logic [lktm_pkg::TableAw-1:0]      wr_addr;
  lktm_pkg::entry_t                  rd_entry, wr_entry;
  logic                              issue, match, out_free;
  logic [lktm_pkg::StampW-1:0]       dist_in, dist_st;
  logic                              in_newer, st_newer, tie, tie_win;
  lktm_pkg::result_t                 res;
  logic                              res_write;
  logic [lktm_pkg::TableAw-1:0]      res_addr;
  logic                              res_append;

  lktm_ram #(
    .Width (lktm_pkg::EntryW),
    .Depth (lktm_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (idx_q[lktm_pkg::TableAw-1:0]),
    .rdata_o (rd_entry)
  );

  assign issue    = (idx_q < used_q);
  assign match    = pend_q && (rd_entry.key == cur_q.entry_key);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign idx_m1   = idx_q - lktm_pkg::CntW'(1);

  // Merge decision on the entry found during the search, or append or drop when the key is not found.
  always_comb begin
    dist_in  = cur_q.stamp - hit_entry_q.stamp;
    dist_st  = hit_entry_q.stamp - cur_q.stamp;
    in_newer = (dist_in < cfg_i.newer_window);
    st_newer = (dist_st < cfg_i.newer_window);
    tie      = (hit_entry_q.stamp == cur_q.stamp) && (hit_entry_q.robot != cur_q.sender_id);
    tie_win  = (cur_q.sender_id >= hit_entry_q.robot);

    res        = '0;
    res_write  = 1'b0;
    res_append = 1'b0;
    res_addr   = hit_addr_q;

    if (hit_q) begin
      if (in_newer || (tie && tie_win && !(cur_q.func == lktm_pkg::FuncQuery && st_newer))) begin
        res_write     = 1'b1;
        res.put_valid = 1'b1;
        res.out_robot = cur_q.sender_id;
        res.out_key   = cur_q.entry_key;
        res.out_value = cur_q.value_word;
        res.out_stamp = cur_q.stamp;
      end else if (cur_q.func == lktm_pkg::FuncQuery && st_newer) begin
        res.put_valid = 1'b1;
        res.out_robot = cfg_i.own_robot_id;
        res.out_key   = cur_q.entry_key;
        res.out_value = hit_entry_q.value;
        res.out_stamp = hit_entry_q.stamp;
      end else if (tie) begin
        // Stored robot id is higher: the stored entry wins and is sent.
        res.put_valid = 1'b1;
        res.out_robot = hit_entry_q.robot;
        res.out_key   = cur_q.entry_key;
        res.out_value = hit_entry_q.value;
        res.out_stamp = hit_entry_q.stamp;
      end
    end else if (used_q == lktm_pkg::CntW'(lktm_pkg::TableDepth)) begin
      res.table_full = 1'b1;
    end else begin
      res_write     = 1'b1;
      res_append    = 1'b1;
      res_addr      = used_q[lktm_pkg::TableAw-1:0];
      res.put_valid = 1'b1;
      res.out_robot = cur_q.sender_id;
      res.out_key   = cur_q.entry_key;
      res.out_value = cur_q.value_word;
      res.out_stamp = cur_q.stamp;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lktm_pkg::StIdle: begin
        if (item_valid_i) begin
          state_d = lktm_pkg::StSearch;
        end
      end
      lktm_pkg::StSearch: begin
        if (match || !issue) begin
          state_d = lktm_pkg::StResolve;
        end
      end
      lktm_pkg::StResolve: begin
        if (out_free) begin
          state_d = lktm_pkg::StIdle;
        end
      end
      default: state_d = lktm_pkg::StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cur_d       = cur_q;
    hit_entry_d = hit_entry_q;
    hit_addr_d  = hit_addr_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    used_d      = used_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    item_pop_o  = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = res_addr;
    wr_entry.key   = cur_q.entry_key;
    wr_entry.robot = cur_q.sender_id;
    wr_entry.value = cur_q.value_word;
    wr_entry.stamp = cur_q.stamp;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      lktm_pkg::StIdle: begin
        item_pop_o = item_valid_i;
        if (item_valid_i) begin
          cur_d  = item_i;
          idx_d  = '0;
          pend_d = 1'b0;
        end
      end
      lktm_pkg::StSearch: begin
        if (match) begin
          hit_d       = 1'b1;
          hit_entry_d = rd_entry;
          hit_addr_d  = idx_m1[lktm_pkg::TableAw-1:0];
        end else if (!issue) begin
          hit_d = 1'b0;
        end else begin
          rd_en  = 1'b1;
          idx_d  = idx_q + lktm_pkg::CntW'(1);
          pend_d = 1'b1;
        end
      end
      lktm_pkg::StResolve: begin
        if (out_free) begin
          wr_en       = res_write;
          out_d       = res;
          out_valid_d = 1'b1;
          if (res_append) begin
            used_d = used_q + lktm_pkg::CntW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lktm_pkg::StIdle;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    hit_entry_q <= hit_entry_d;
    hit_addr_q  <= hit_addr_d;
    out_q       <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.out_stamp, out_q.out_value, out_q.out_key, out_q.out_robot};
  assign m_axis_tuser_o  = {out_q.table_full, out_q.put_valid};

  assign status_o.used_slots = used_q;

endmodule

// File: design/lamport_keyed_table_merge.sv
// ----------------------------------------------------------------------------
// lamport_keyed_table_merge: keyed last-writer-wins table with Lamport stamps
// Merges put and query messages into a table ordered by circular 8-bit
// stamps and sends one result per message.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                Contents
//  --------  ---------  -------------------  ------------------------------------
//  s_axis    in         tvalid/tready/tdata  message: key, stamp, sender, value
//                       tuser                message kind (0 put, 1 query)
//  m_axis    out        tvalid/tready/tdata  put: robot, key, value, stamp
//                       tuser                put_valid, table_full
//  cfg       in         we/addr/wdata        newer_window (0), own_robot_id (1)
//
// A message leaving the intake queue is handled in order: the back end takes
// it, reads the table one filled slot at a time until the key is found, with
// a final compare, then merges, writes back and registers the result once the
// output register is free. It works on one message at a time, and the single
// read port of the table RAM makes the search visit the slots one by one.
// Reset is asynchronous and clears the slot count, so the table itself needs
// no clearing pass. While it has room, the two-entry intake queue accepts
// transactions as the back end works or a result waits for the downstream side.
//
module lamport_keyed_table_merge (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: entry_key[15:0], stamp[7:0], sender_id[15:0], value_word[23:0]
  input  logic [63:0] s_axis_tdata,
  // tuser: func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: out_robot[15:0], out_key[15:0], out_value[23:0], out_stamp[7:0]
  output logic [63:0] m_axis_tdata,
  // tuser from bit 0: put_valid, table_full
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  lktm_pkg::cfg_t     cfg_q;
  lktm_pkg::item_t    item;
  logic               item_valid, item_pop;
  lktm_pkg::status_t  status;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.newer_window <= lktm_pkg::WindowReset;
      cfg_q.own_robot_id <= lktm_pkg::OwnIdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lktm_pkg::CfgNewerWindow: cfg_q.newer_window <= cfg_wdata_i[7:0];
        lktm_pkg::CfgOwnRobotId:  cfg_q.own_robot_id <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lktm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  lktm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_pop_o      (item_pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .status_o        (status)
  );

  // A dropped message never carries a put as well.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result flags both a put and a full table");

  // A result without a put carries all-zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("result without a put has non-zero data");

  // The slot count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.used_slots <= lktm_pkg::CntW'(lktm_pkg::TableDepth))
    else $error("slot count beyond table depth");

  // The slot count only grows, by at most one, and only with a put result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.used_slots != $past(status.used_slots)) |->
      (status.used_slots == $past(status.used_slots) + lktm_pkg::CntW'(1))
      && m_axis_tvalid && m_axis_tuser[0])
    else $error("slot count changed unexpectedly");

endmodule

// File: tb/lamport_keyed_table_merge_tb.sv
// ----------------------------------------------------------------------------
// lamport_keyed_table_merge_tb: self-checking bench for the keyed stamp table
// Drives put and query messages through the input stream, predicts every
// result with an independent model of the table and its merge rules, and
// compares each output transaction field by field under varied flow control.
// ----------------------------------------------------------------------------
module lamport_keyed_table_merge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // --------------------------------------------------------------------------
  // Block connections. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata from bit 0: entry_key[15:0], stamp[7:0], sender_id[15:0], value_word[23:0]
  logic [63:0] s_axis_tdata  = '0;
  // tuser: func
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata from bit 0: out_robot[15:0], out_key[15:0], out_value[23:0], out_stamp[7:0]
  logic [63:0] m_axis_tdata;
  // tuser from bit 0: put_valid, table_full
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_addr_i    = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;

  lamport_keyed_table_merge u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog. The slowest correct run is roughly 830 messages; the time limit
  // leaves ample margin over it.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Independent model of the table. It mirrors the block's slots and its
  // two configuration registers, and is advanced once per accepted message.
  // --------------------------------------------------------------------------
  logic [lktm_pkg::KeyW-1:0]   tbl_key   [lktm_pkg::TableDepth];
  logic [lktm_pkg::RobotW-1:0] tbl_robot [lktm_pkg::TableDepth];
  logic [lktm_pkg::ValueW-1:0] tbl_value [lktm_pkg::TableDepth];
  logic [lktm_pkg::StampW-1:0] tbl_stamp [lktm_pkg::TableDepth];
  int unsigned                 n_filled    = 0;
  logic [lktm_pkg::StampW-1:0] cur_window  = lktm_pkg::WindowReset;
  logic [lktm_pkg::RobotW-1:0] cur_own_id  = lktm_pkg::OwnIdReset;

  // Results still owed by the block, oldest first.
  lktm_pkg::result_t predicted_puts [$];
  int unsigned       mismatch_count = 0;

  // Flow-control pacing, in percent of cycles.
  int unsigned send_gap_pct    = 0;
  int unsigned ready_stall_pct = 0;

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Stamps live on a circle of 256: a is newer than b when the forward
  // distance from b to a is below the window.
  function automatic bit is_newer(logic [lktm_pkg::StampW-1:0] a,
                                  logic [lktm_pkg::StampW-1:0] b);
    logic [lktm_pkg::StampW-1:0] gap;
    gap = a - b;
    return gap < cur_window;
  endfunction

  function automatic lktm_pkg::result_t put_of(logic [lktm_pkg::RobotW-1:0] robot,
                                               logic [lktm_pkg::KeyW-1:0]   key,
                                               logic [lktm_pkg::ValueW-1:0] value,
                                               logic [lktm_pkg::StampW-1:0] stamp);
    lktm_pkg::result_t r;
    r           = '0;
    r.put_valid = 1'b1;
    r.out_robot = robot;
    r.out_key   = key;
    r.out_value = value;
    r.out_stamp = stamp;
    return r;
  endfunction

  function automatic lktm_pkg::item_t msg(lktm_pkg::func_e f,
                                          logic [lktm_pkg::KeyW-1:0]   key,
                                          logic [lktm_pkg::StampW-1:0] stamp,
                                          logic [lktm_pkg::RobotW-1:0] sender,
                                          logic [lktm_pkg::ValueW-1:0] value);
    lktm_pkg::item_t m;
    m.func       = f;
    m.entry_key  = key;
    m.stamp      = stamp;
    m.sender_id  = sender;
    m.value_word = value;
    return m;
  endfunction

  // Applies one message to the model table and returns the result that the
  // block must send for it.
  function automatic lktm_pkg::result_t merge_message(lktm_pkg::item_t m);
    lktm_pkg::result_t r;
    bit                hit;
    r   = '0;
    hit = 1'b0;
    for (int i = 0; i < n_filled; i++) begin
      if (!hit && tbl_key[i] == m.entry_key) begin
        hit = 1'b1;
        if (is_newer(m.stamp, tbl_stamp[i])) begin
          // Newer stamp: the incoming entry replaces the stored one.
          tbl_robot[i] = m.sender_id;
          tbl_value[i] = m.value_word;
          tbl_stamp[i] = m.stamp;
          r = put_of(m.sender_id, m.entry_key, m.value_word, m.stamp);
        end else if (m.func == lktm_pkg::FuncQuery && is_newer(tbl_stamp[i], m.stamp)) begin
          // A query behind our copy: echo the stored entry under our own id.
          r = put_of(cur_own_id, m.entry_key, tbl_value[i], tbl_stamp[i]);
        end else if (tbl_stamp[i] == m.stamp && tbl_robot[i] != m.sender_id) begin
          // Same stamp from another robot: the higher robot id wins, and the
          // winner is sent either way.
          if (m.sender_id >= tbl_robot[i]) begin
            tbl_robot[i] = m.sender_id;
            tbl_value[i] = m.value_word;
          end
          r = put_of(tbl_robot[i], m.entry_key, tbl_value[i], tbl_stamp[i]);
        end
      end
    end
    if (!hit) begin
      if (n_filled >= lktm_pkg::TableDepth) begin
        // Unknown key and no room left: dropped and flagged.
        r.table_full = 1'b1;
      end else begin
        tbl_key[n_filled]   = m.entry_key;
        tbl_robot[n_filled] = m.sender_id;
        tbl_value[n_filled] = m.value_word;
        tbl_stamp[n_filled] = m.stamp;
        n_filled++;
        r = put_of(m.sender_id, m.entry_key, m.value_word, m.stamp);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Output side. tready is redrawn at every rising edge; a transaction is
  // recognised at the falling edge before the rising edge that completes it,
  // when valid, ready and data are all settled.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 200) begin
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_put(lktm_pkg::result_t got);
    lktm_pkg::result_t want;
    if (predicted_puts.size() == 0) begin
      report_mismatch("output transaction with nothing outstanding", 32'(got.out_key), 32'd0);
    end else begin
      want = predicted_puts.pop_front();
      if (got.put_valid != want.put_valid)
        report_mismatch("put_valid", 32'(got.put_valid), 32'(want.put_valid));
      if (got.table_full != want.table_full)
        report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
      if (got.out_robot != want.out_robot)
        report_mismatch("out_robot", 32'(got.out_robot), 32'(want.out_robot));
      if (got.out_key != want.out_key)
        report_mismatch("out_key", 32'(got.out_key), 32'(want.out_key));
      if (got.out_value != want.out_value)
        report_mismatch("out_value", 32'(got.out_value), 32'(want.out_value));
      if (got.out_stamp != want.out_stamp)
        report_mismatch("out_stamp", 32'(got.out_stamp), 32'(want.out_stamp));
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !chance(ready_stall_pct);
  end

  always @(negedge clk_i) begin
    lktm_pkg::result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got            = '0;
      got.out_robot  = m_axis_tdata[15:0];
      got.out_key    = m_axis_tdata[31:16];
      got.out_value  = m_axis_tdata[55:32];
      got.out_stamp  = m_axis_tdata[63:56];
      got.put_valid  = m_axis_tuser[0];
      got.table_full = m_axis_tuser[1];
      check_put(got);
    end
  end

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------

  // Modes: 0 no idling, 1 sender gaps, 2 receiver stalls, 3 light idling on
  // both sides.
  task automatic set_pacing(int unsigned mode);
    case (mode)
      1: begin
        send_gap_pct    = 47;
        ready_stall_pct = 0;
      end
      2: begin
        send_gap_pct    = 0;
        ready_stall_pct = 47;
      end
      3: begin
        send_gap_pct    = 12;
        ready_stall_pct = 12;
      end
      default: begin
        send_gap_pct    = 0;
        ready_stall_pct = 0;
      end
    endcase
  endtask

  // Presents one message, holds it until the transaction completes, and
  // records the expected result. Called and returns at a rising edge. A typed
  // expectation, where given, replaces the model's; the model still runs so
  // that its table follows the block.
  task automatic send_message(lktm_pkg::item_t m, bit typed, lktm_pkg::result_t want);
    bit                fire;
    lktm_pkg::result_t predicted;
    while (chance(send_gap_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {m.value_word, m.sender_id, m.stamp, m.entry_key};
    s_axis_tuser  <= m.func;
    do begin
      @(negedge clk_i);
      fire = s_axis_tready;
      if (fire) begin
        predicted = merge_message(m);
        predicted_puts.push_back(typed ? want : predicted);
      end
      @(posedge clk_i);
    end while (!fire);
  endtask

  // Register writes happen only with the block idle: the input is quiet,
  // every result has come back, and the back end has had time to settle.
  task automatic write_register(logic sel, logic [15:0] data);
    s_axis_tvalid <= 1'b0;
    while (predicted_puts.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= sel;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (sel == lktm_pkg::CfgNewerWindow) cur_window = data[lktm_pkg::StampW-1:0];
    else cur_own_id = data;
  endtask

  // Random messages mostly hit keys already held, with stamps placed just
  // ahead of, just behind or equal to the stored one, or drawn at random, so
  // that every merge rule fires; the rest carry random keys and stamps.
  function automatic lktm_pkg::item_t random_message();
    lktm_pkg::item_t             m;
    int unsigned                 slot;
    logic [lktm_pkg::StampW-1:0] base_stamp;
    logic [lktm_pkg::RobotW-1:0] base_robot;
    m.func = lktm_pkg::func_e'($urandom_range(0, 1));
    if (n_filled != 0 && chance(85)) begin
      slot        = $urandom_range(0, n_filled - 1);
      m.entry_key = tbl_key[slot];
      base_stamp  = tbl_stamp[slot];
      base_robot  = tbl_robot[slot];
    end else begin
      m.entry_key = lktm_pkg::KeyW'($urandom);
      base_stamp  = lktm_pkg::StampW'($urandom);
      base_robot  = lktm_pkg::RobotW'($urandom);
    end
    case ($urandom_range(0, 3))
      0:       m.stamp = base_stamp + lktm_pkg::StampW'($urandom_range(0, 60));
      1:       m.stamp = base_stamp - lktm_pkg::StampW'($urandom_range(0, 60));
      2:       m.stamp = base_stamp;
      default: m.stamp = lktm_pkg::StampW'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       m.sender_id = base_robot;
      1:       m.sender_id = lktm_pkg::RobotW'($urandom_range(0, 3));
      2:       m.sender_id = ~lktm_pkg::RobotW'($urandom_range(0, 3));
      default: m.sender_id = lktm_pkg::RobotW'($urandom);
    endcase
    m.value_word = lktm_pkg::ValueW'($urandom);
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Directed script. A row either writes a register or sends a message; the
  // expected result is typed in only where it is plain from the rules.
  // --------------------------------------------------------------------------
  typedef struct {
    bit                is_write;
    logic              cfg_sel;
    logic [15:0]       cfg_value;
    lktm_pkg::item_t   m;
    bit                typed;
    lktm_pkg::result_t want;
  } script_row_t;

  script_row_t script [$];

  initial begin
    logic [lktm_pkg::StampW-1:0] phase_window;
    logic [lktm_pkg::RobotW-1:0] phase_own_id;

    // Window 50 and own id 0 after reset. The two extreme keys go in first.
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncPut, 16'h0000, 8'h00, 16'h0000, 24'h000000),
                       1, put_of(16'h0000, 16'h0000, 24'h000000, 8'h00)});
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncPut, 16'hFFFF, 8'hFF, 16'hFFFF, 24'hFFFFFF),
                       1, put_of(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'hFF)});
    // A query with the same stamp: zero distance counts as newer.
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncQuery, 16'h0000, 8'h00, 16'h0005, 24'h123456),
                       0, '0});
    // Half a circle away in either direction: neither side is newer.
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncPut, 16'hFFFF, 8'h80, 16'h0001, 24'h00BEEF),
                       0, '0});
    // A query slightly behind the stored stamp is answered with an echo.
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncQuery, 16'hFFFF, 8'hF0, 16'h0002, 24'h0),
                       0, '0});
    script.push_back('{1, lktm_pkg::CfgOwnRobotId, 16'hFFFF, '0, 0, '0});
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncQuery, 16'hFFFF, 8'hF0, 16'h0003, 24'h0),
                       0, '0});
    // Newer across the wrap from 0xFF to 0x10.
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncPut, 16'hFFFF, 8'h10, 16'h0007, 24'hABCDEF),
                       0, '0});
    // With a zero window nothing is newer and equal stamps go to the
    // robot-id tie-break: higher id wins, lower id gets the stored winner
    // back, the same robot gets nothing.
    script.push_back('{1, lktm_pkg::CfgNewerWindow, 16'h0000, '0, 0, '0});
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncPut, 16'hFFFF, 8'h10, 16'h0009, 24'h111111),
                       0, '0});
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncPut, 16'hFFFF, 8'h10, 16'h0008, 24'h222222),
                       0, '0});
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncPut, 16'hFFFF, 8'h10, 16'h0009, 24'h333333),
                       0, '0});
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncQuery, 16'hFFFF, 8'h11, 16'h0004, 24'h444444),
                       0, '0});
    // Widest window: only a distance of 255 fails to count as newer.
    script.push_back('{1, lktm_pkg::CfgNewerWindow, 16'h00FF, '0, 0, '0});
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncQuery, 16'h0000, 8'hFF, 16'h0006, 24'h555555),
                       0, '0});
    // Fill the remaining slots, one key bit at a time.
    for (int i = 0; i < 14; i++) begin
      script.push_back('{0, 1'b0, 16'h0,
                         msg(lktm_pkg::FuncPut, 16'h0001 << i, 8'(i * 19),
                             16'hA5A5 ^ 16'(i), {8'(i), 16'h5A5A}),
                         1, put_of(16'hA5A5 ^ 16'(i), 16'h0001 << i, {8'(i), 16'h5A5A},
                                   8'(i * 19))});
    end
    // Table full: an unknown key is dropped and flagged.
    script.push_back('{0, 1'b0, 16'h0,
                       msg(lktm_pkg::FuncPut, 16'h4000, 8'h20, 16'h0001, 24'h0),
                       1, '{table_full: 1'b1, default: '0}});

    // Reset is held from time zero and released at a rising edge.
    set_pacing(0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_write) write_register(script[i].cfg_sel, script[i].cfg_value);
      else send_message(script[i].m, script[i].typed, script[i].want);
    end

    // Random phases, each with its own register settings and pacing.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       phase_window = 8'd50;
        1:       phase_window = 8'd0;
        2:       phase_window = 8'd255;
        3:       phase_window = 8'd1;
        4:       phase_window = 8'd0;
        5:       phase_window = lktm_pkg::StampW'($urandom);
        6:       phase_window = 8'd128;
        default: phase_window = 8'd0;
      endcase
      case (phase % 3)
        0:       phase_own_id = 16'h0000;
        1:       phase_own_id = 16'hFFFF;
        default: phase_own_id = lktm_pkg::RobotW'($urandom);
      endcase
      write_register(lktm_pkg::CfgNewerWindow, {8'h00, phase_window});
      write_register(lktm_pkg::CfgOwnRobotId, phase_own_id);
      set_pacing(phase % 4);
      for (int n = 0; n < 100; n++) begin
        send_message(random_message(), 0, '0);
      end
    end

    // Drain, then give the block time to show any stray transaction.
    s_axis_tvalid <= 1'b0;
    while (predicted_puts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
